[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is low.
`define AJIC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never hold at a clock edge out of reset.
`define AJIC_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

[hdl/ajic_pkg.sv]
package ajic_pkg;

  // 2^32 nonces * 0.7, in kH
  localparam logic [31:0] JOB_WORK_KH     = 32'd3006477107;
  // 100 GH/s in kH/s
  localparam logic [39:0] RATE_THRESH_KHS = 40'd100000000;
  localparam logic [15:0] ADOPT_DELTA_MS  = 16'd10;
  localparam logic [15:0] CONF_RESET_MS   = 16'd500;
  localparam logic [15:0] MIN_INTERVAL_MS = 16'd200;

  localparam int unsigned RATE_W   = 40;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned QUO_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CNT_W    = $clog2(QUO_W);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CONF_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_RATE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_TGT,
    ST_BLEND
  } state_e;

  typedef struct packed {
    logic load;    // latch divisor, reset divider
    logic step;    // one restoring division step
    logic tgt;     // form clamped target
    logic commit;  // update interval, load output register
  } cmd_t;

  typedef struct packed {
    logic adaptive;  // nominal rate is nonzero
    logic out_free;  // output register can take a beat
  } sts_t;

endpackage

[hdl/ajic_ctrl.sv]
`include "assert_macros.svh"

module ajic_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ajic_pkg::sts_t sts_i,
  output ajic_pkg::cmd_t cmd_o
);

  ajic_pkg::state_e state_q, state_d;
  logic [ajic_pkg::CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ajic_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ajic_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cnt_d   = ajic_pkg::CNT_W'(ajic_pkg::QUO_W - 1);
          state_d = sts_i.adaptive ? ajic_pkg::ST_DIV : ajic_pkg::ST_BLEND;
        end
      end
      ajic_pkg::ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ajic_pkg::ST_TGT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ajic_pkg::ST_TGT: begin
        state_d = ajic_pkg::ST_BLEND;
      end
      ajic_pkg::ST_BLEND: begin
        if (sts_i.out_free) begin
          state_d = ajic_pkg::ST_IDLE;
        end
      end
      default: state_d = ajic_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ajic_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      ajic_pkg::ST_DIV:   cmd_o.step   = 1'b1;
      ajic_pkg::ST_TGT:   cmd_o.tgt    = 1'b1;
      ajic_pkg::ST_BLEND: cmd_o.commit = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  `AJIC_ASSERT(a_cnt_dec, clk_i, rst_ni,
    (state_q == ajic_pkg::ST_DIV && cnt_q != '0) |=> (cnt_q == $past(cnt_q) - 1'b1),
    "divide step counter did not count down")
  `AJIC_ASSERT(a_load_next, clk_i, rst_ni,
    cmd_o.load |=> (state_q == ajic_pkg::ST_DIV || state_q == ajic_pkg::ST_BLEND),
    "accepted beat did not start work")

endmodule

[hdl/ajic_dp.sv]
`include "assert_macros.svh"

module ajic_dp #(
  parameter logic [15:0] MIN_INTERVAL_MS = ajic_pkg::MIN_INTERVAL_MS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ajic_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ajic_pkg::RATE_W-1:0]        cfg_data_i,
  input  logic [ajic_pkg::RATE_W-1:0]        measured_rate_khs_i,
  input  ajic_pkg::cmd_t                     cmd_i,
  output ajic_pkg::sts_t                     sts_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [ajic_pkg::MS_W-1:0]          period_ms_o,
  output logic [ajic_pkg::MS_W-1:0]          goal_ms_o,
  output logic                               changed_o
);

  localparam int unsigned RW = ajic_pkg::RATE_W;
  localparam int unsigned MW = ajic_pkg::MS_W;
  localparam int unsigned QW = ajic_pkg::QUO_W;
  localparam logic [MW-1:0] CUR_RESET =
    (ajic_pkg::CONF_RESET_MS < MIN_INTERVAL_MS) ? MIN_INTERVAL_MS : ajic_pkg::CONF_RESET_MS;

  logic [MW-1:0] conf_q, cur_q, target_q;
  logic [RW-1:0] nom_q, divisor_q, rem_q;
  logic [QW-1:0] quo_q;
  logic          adapt_q;
  logic          m_valid_q, m_chg_q;
  logic [MW-1:0] m_int_q, m_tgt_q;

  logic [MW-1:0] conf_eff, cfg_conf_eff;

  assign conf_eff     = (conf_q < MIN_INTERVAL_MS) ? MIN_INTERVAL_MS : conf_q;
  assign cfg_conf_eff = (cfg_data_i[MW-1:0] < MIN_INTERVAL_MS) ? MIN_INTERVAL_MS
                                                               : cfg_data_i[MW-1:0];

  // restoring divide step
  logic [RW:0]   trial, trial_sub;
  logic          ge;
  assign trial     = {rem_q, quo_q[QW-1]};
  assign ge        = trial >= {1'b0, divisor_q};
  assign trial_sub = trial - {1'b0, divisor_q};

  // ceiling and clamp
  logic [QW:0]   t_ceil, t_min;
  logic [MW-1:0] t_clamp;
  assign t_ceil  = {1'b0, quo_q} + (QW+1)'(rem_q != '0);
  assign t_min   = (t_ceil < (QW+1)'(MIN_INTERVAL_MS)) ? (QW+1)'(MIN_INTERVAL_MS) : t_ceil;
  assign t_clamp = (t_min > (QW+1)'(conf_eff)) ? conf_eff : t_min[MW-1:0];

  // blend toward target
  logic [MW+1:0] down_sum;
  logic [MW+2:0] up_sum;
  logic [MW-1:0] down_v, up_v, up_cap, next_v, diff;
  logic          chg;
  assign down_sum = (MW+2)'(cur_q) * (MW+2)'(3) + (MW+2)'(target_q);
  assign up_sum   = (MW+3)'(cur_q) * (MW+3)'(7) + (MW+3)'(target_q);
  assign down_v   = down_sum[MW+1:2];
  assign up_v     = up_sum[MW+2:3];
  assign up_cap   = (up_v > conf_eff) ? conf_eff : up_v;

  always_comb begin
    next_v = cur_q;
    if (target_q < cur_q) begin
      next_v = (down_v < MIN_INTERVAL_MS) ? MIN_INTERVAL_MS : down_v;
    end else if (target_q > cur_q) begin
      next_v = (up_cap < MIN_INTERVAL_MS) ? MIN_INTERVAL_MS : up_cap;
    end
  end

  assign diff = (next_v > cur_q) ? (next_v - cur_q) : (cur_q - next_v);
  assign chg  = adapt_q && (diff >= ajic_pkg::ADOPT_DELTA_MS);

  // config and kept interval
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_q <= ajic_pkg::CONF_RESET_MS;
      nom_q  <= '0;
      cur_q  <= CUR_RESET;
    end else begin
      if (cfg_we_i && cfg_idx_i == ajic_pkg::REG_CONF_INTERVAL) begin
        conf_q <= cfg_data_i[MW-1:0];
        cur_q  <= cfg_conf_eff;
      end else if (cmd_i.commit && chg) begin
        cur_q  <= next_v;
      end
      if (cfg_we_i && cfg_idx_i == ajic_pkg::REG_NOMINAL_RATE) begin
        nom_q <= cfg_data_i;
      end
    end
  end

  // divider and target
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      divisor_q <= (measured_rate_khs_i > ajic_pkg::RATE_THRESH_KHS) ? measured_rate_khs_i
                                                                      : nom_q;
      rem_q     <= '0;
      quo_q     <= ajic_pkg::JOB_WORK_KH;
      target_q  <= '0;
      adapt_q   <= (nom_q != '0);
    end else if (cmd_i.step) begin
      rem_q <= ge ? trial_sub[RW-1:0] : trial[RW-1:0];
      quo_q <= {quo_q[QW-2:0], ge};
    end else if (cmd_i.tgt) begin
      target_q <= t_clamp;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      m_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      m_int_q <= chg ? next_v : cur_q;
      m_tgt_q <= target_q;
      m_chg_q <= chg;
    end
  end

  assign sts_o.adaptive = (nom_q != '0);
  assign sts_o.out_free = !m_valid_q || out_ready_i;
  assign out_valid_o    = m_valid_q;
  assign period_ms_o    = m_int_q;
  assign goal_ms_o      = m_tgt_q;
  assign changed_o      = m_chg_q;

  `AJIC_NEVER(a_cur_floor, clk_i, rst_ni, cur_q < MIN_INTERVAL_MS,
    "kept interval below minimum")
  `AJIC_NEVER(a_commit_full, clk_i, rst_ni, cmd_i.commit && m_valid_q && !out_ready_i,
    "result overwrote a beat not yet taken")

endmodule

[hdl/adaptive_job_interval_controller_unit.sv]
// Channel   | Dir | Beat fields (tdata/tuser, low bit up)
// s_axis    | in  | tdata[39:0] measured_rate_khs
// m_axis    | out | tdata[15:0] interval, [31:16] target, [32] changed, [39:33] zero
// cfg       | in  | cfg_idx_i 0: configured interval[15:0], 1: nominal_rate_khs[39:0]
//
// Sequence: an adaptive beat runs 32 restoring divide steps on a 41-bit subtractor, then a
//   target clamp step and a blend/commit step, after which the unit returns to idle for the next
//   beat; with nominal rate zero the divider is skipped and the beat goes to blend/commit.
// Reset: async active low; interval = max(500, MIN_INTERVAL_MS), nominal rate 0.
// Stalls: one output register; a new beat is accepted while it waits and its result
//   holds in the blend step until the slot frees. Cfg index 0 also reloads the interval.

module adaptive_job_interval_controller_unit #(
  parameter logic [15:0] MIN_INTERVAL_MS = ajic_pkg::MIN_INTERVAL_MS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [ajic_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ajic_pkg::RATE_W-1:0]    cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [39:0]                    s_axis_tdata,  // [39:0] measured_rate_khs
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [39:0]                    m_axis_tdata   // [15:0] interval,
                                                        // [31:16] target, [32] changed
);

  ajic_pkg::cmd_t cmd;
  ajic_pkg::sts_t sts;

  logic [ajic_pkg::MS_W-1:0] period_ms, goal_ms;
  logic                      changed;

  // sequencer: accept, divide count, clamp, commit
  ajic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // registers, divider, blend and output register
  ajic_dp #(
    .MIN_INTERVAL_MS (MIN_INTERVAL_MS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .measured_rate_khs_i (s_axis_tdata),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_ready_i         (m_axis_tready),
    .out_valid_o         (m_axis_tvalid),
    .period_ms_o         (period_ms),
    .goal_ms_o           (goal_ms),
    .changed_o           (changed)
  );

  assign m_axis_tdata = {7'd0, changed, goal_ms, period_ms};

endmodule

[tb/adaptive_job_interval_controller_unit_test.sv]
`timescale 1ns / 1ps

module adaptive_job_interval_controller_unit_test;

  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned TIMEOUT_CYC  = 400_000;
  localparam int unsigned HOLD_CYC     = 300;   // long output hold-off
  localparam int unsigned SETTLE_CYC   = 40;    // longer than the adaptive beat latency
  localparam int unsigned PHASES       = 10;
  localparam int unsigned JOBS_PER_PH  = 64;
  localparam logic [39:0] RATE_MAX     = 40'hFF_FFFF_FFFF;

  // One result beat, low field in the low bits to match m_axis_tdata[32:0].
  typedef struct packed {
    logic        changed;
    logic [15:0] goal_ms;
    logic [15:0] period_ms;
  } interval_beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                           cfg_we   = 1'b0;
  logic [ajic_pkg::CFG_IDX_W-1:0] cfg_idx  = '0;
  logic [ajic_pkg::RATE_W-1:0]    cfg_data = '0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  // Shadow of the block: register copies and the kept interval.
  logic [15:0] conf_ms;
  logic [39:0] nominal_khs;
  logic [15:0] kept_ms;

  logic [39:0]    job_rates_q[$];        // measured rates waiting for the driver
  interval_beat_t pending_intervals[$];  // predicted results, oldest first

  int unsigned tx_wait, rx_wait, rx_wait_nxt;
  bit          tx_rush, rx_rush;  // no idling on that side while set
  bit          hold_req;
  logic        rx_hold = 1'b0;

  int unsigned err_cnt, jobs_taken, results_seen, updates_seen, off_jobs, reg_writes;

  adaptive_job_interval_controller_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Interval update for one dispatched job; advances the kept interval.
  function automatic interval_beat_t predict_interval(input logic [39:0] measured);
    interval_beat_t res;
    logic [15:0]    eff_conf;
    logic [63:0]    rate, quo;
    logic [31:0]    cur, tgt, nxt, blend, delta;
    res      = '0;
    eff_conf = (conf_ms < ajic_pkg::MIN_INTERVAL_MS) ? ajic_pkg::MIN_INTERVAL_MS : conf_ms;
    cur      = 32'(kept_ms);
    tgt      = '0;
    nxt      = cur;
    if (nominal_khs != '0) begin
      // measured rate only trusted above 100 GH/s
      rate = (measured > ajic_pkg::RATE_THRESH_KHS) ? 64'(measured) : 64'(nominal_khs);
      quo  = 64'(ajic_pkg::JOB_WORK_KH) / rate;
      if ((64'(ajic_pkg::JOB_WORK_KH) % rate) != 0) quo = quo + 1;  // ceiling
      if (quo < 64'(ajic_pkg::MIN_INTERVAL_MS)) quo = 64'(ajic_pkg::MIN_INTERVAL_MS);
      if (quo > 64'(eff_conf)) quo = 64'(eff_conf);
      tgt = quo[31:0];
      if (tgt < cur) begin
        // quarter step down
        nxt = (cur * 3 + tgt) / 4;
        if (nxt < 32'(ajic_pkg::MIN_INTERVAL_MS)) nxt = 32'(ajic_pkg::MIN_INTERVAL_MS);
      end else if (tgt > cur) begin
        // eighth step up, never past the configured interval
        blend = (cur * 7 + tgt) / 8;
        if (blend > 32'(eff_conf)) blend = 32'(eff_conf);
        nxt = (blend < 32'(ajic_pkg::MIN_INTERVAL_MS)) ? 32'(ajic_pkg::MIN_INTERVAL_MS)
                                                       : blend;
      end
      delta = (nxt > cur) ? nxt - cur : cur - nxt;
      // small moves are dropped
      if (delta >= 32'(ajic_pkg::ADOPT_DELTA_MS)) begin
        kept_ms     = nxt[15:0];
        res.changed = 1'b1;
      end
    end else begin
      off_jobs++;
    end
    res.period_ms = kept_ms;
    res.goal_ms   = tgt[15:0];
    return res;
  endfunction

  function automatic int unsigned draw_gap(input bit rush);
    return rush ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [39:0] draw_full40();
    return {8'($urandom_range(0, 255)), 32'($urandom)};
  endfunction

  // Measured rates: both sides of the 100 GH/s threshold, extremes, noise.
  function automatic logic [39:0] draw_measured();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ajic_pkg::RATE_THRESH_KHS;
      2:       return ajic_pkg::RATE_THRESH_KHS + 40'd1;
      3:       return RATE_MAX;
      4, 5:    return draw_full40();
      6, 7, 8: return 40'($urandom_range(0, 100_000_000));
      default: return ajic_pkg::RATE_THRESH_KHS + 40'($urandom);
    endcase
  endfunction

  // Nominal rates often in the band where targets land between 151 and 752 ms.
  function automatic logic [39:0] draw_nominal();
    case ($urandom_range(0, 7))
      0:          return 40'd1;
      1:          return RATE_MAX;
      2:          return draw_full40();
      3, 4, 5:    return 40'($urandom_range(4_000_000, 20_000_000));
      6:          return 40'($urandom_range(1, 3_000_000));
      default:    return '0;  // adaptive off
    endcase
  endfunction

  function automatic logic [15:0] draw_conf();
    case ($urandom_range(0, 8))
      0:          return 16'd0;
      1:          return ajic_pkg::MIN_INTERVAL_MS - 16'd1;
      2:          return ajic_pkg::MIN_INTERVAL_MS;
      3:          return ajic_pkg::MIN_INTERVAL_MS + 16'd1;
      4:          return 16'hFFFF;
      5, 6, 7:    return 16'($urandom_range(200, 1500));
      default:    return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned exp_v,
                                 input longint unsigned got_v);
    $display("[%0t] mismatch %s: expected %0d got %0d (result %0d)",
             $time, what, exp_v, got_v, results_seen);
    err_cnt++;
  endtask

  // Only called while idle. Index 0 also reloads the kept interval.
  task automatic apply_register(input logic [ajic_pkg::CFG_IDX_W-1:0] idx,
                                input logic [39:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == ajic_pkg::REG_CONF_INTERVAL) begin
      conf_ms = value[15:0];
      kept_ms = (conf_ms < ajic_pkg::MIN_INTERVAL_MS) ? ajic_pkg::MIN_INTERVAL_MS : conf_ms;
    end else begin
      nominal_khs = value;
    end
    reg_writes++;
  endtask

  task automatic queue_job(input logic [39:0] measured);
    job_rates_q.push_back(measured);
  endtask

  // Sampled on the falling edge, away from the driver and monitor updates.
  task automatic drain_results();
    do @(negedge clk_i);
    while (job_rates_q.size() != 0 || s_axis_tvalid || pending_intervals.size() != 0);
  endtask

  // Driver: one beat at a time, random gap after each accepted beat.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_wait       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_intervals.push_back(predict_interval(s_axis_tdata));
        jobs_taken++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // beat still offered, hold it
      end else if (tx_wait != 0) begin
        s_axis_tvalid <= 1'b0;
        tx_wait       <= tx_wait - 1;
      end else if (job_rates_q.size() != 0) begin
        s_axis_tdata  <= job_rates_q.pop_front();
        s_axis_tvalid <= 1'b1;
        tx_wait       <= draw_gap(tx_rush);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor / receiver: checks each result beat, then stalls a random while.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
    end else begin
      rx_wait_nxt = rx_wait;
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_intervals.size() == 0) begin
          report_mismatch("result with nothing pending", 0, m_axis_tdata);
        end else begin
          interval_beat_t exp_b, got_b;
          exp_b = pending_intervals.pop_front();
          got_b = interval_beat_t'(m_axis_tdata[32:0]);
          if (got_b.period_ms !== exp_b.period_ms)
            report_mismatch("interval", exp_b.period_ms, got_b.period_ms);
          if (got_b.goal_ms !== exp_b.goal_ms)
            report_mismatch("target", exp_b.goal_ms, got_b.goal_ms);
          if (got_b.changed !== exp_b.changed)
            report_mismatch("changed", exp_b.changed, got_b.changed);
          if (m_axis_tdata[39:33] !== 7'd0)
            report_mismatch("tdata padding", 0, m_axis_tdata[39:33]);
          if (exp_b.changed) updates_seen++;
        end
        results_seen++;
        rx_wait_nxt = draw_gap(rx_rush);
      end else if (rx_wait != 0) begin
        rx_wait_nxt = rx_wait - 1;
      end
      rx_wait       <= rx_wait_nxt;
      m_axis_tready <= (rx_wait_nxt == 0) && !rx_hold;
    end
  end

  // Long output hold-off, triggered once by the stimulus.
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #(TIMEOUT_CYC * CLK_PERIOD);
    $display("adaptive_job_interval_controller_unit regression: fail");
    $finish;
  end

  initial begin
    int unsigned ph, n;
    logic [15:0] conf_v;
    logic [39:0] nom_v;

    // reset state of the shadow
    conf_ms     = ajic_pkg::CONF_RESET_MS;
    nominal_khs = '0;
    kept_ms     = (ajic_pkg::CONF_RESET_MS < ajic_pkg::MIN_INTERVAL_MS) ?
                  ajic_pkg::MIN_INTERVAL_MS : ajic_pkg::CONF_RESET_MS;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed ---
    // adaptive off: target 0, interval kept
    queue_job('0);
    queue_job(RATE_MAX);
    queue_job(ajic_pkg::RATE_THRESH_KHS);
    drain_results();

    // widest interval, fastest nominal: big quarter steps down toward a target of 200
    apply_register(ajic_pkg::REG_NOMINAL_RATE, RATE_MAX);
    apply_register(ajic_pkg::REG_CONF_INTERVAL, {24'hA5_5A_C3, 16'hFFFF});
    queue_job('0);
    queue_job(ajic_pkg::RATE_THRESH_KHS + 40'd1);
    queue_job(RATE_MAX);
    drain_results();

    // slowest nominal: target pinned to configured, eighth steps up
    apply_register(ajic_pkg::REG_NOMINAL_RATE, 40'd1);
    queue_job(40'd1);
    queue_job(ajic_pkg::RATE_THRESH_KHS);
    drain_results();

    // configured below the floor: kept interval forced to 200
    apply_register(ajic_pkg::REG_CONF_INTERVAL, 40'd0);
    queue_job('0);
    drain_results();

    // 280 -> 260 -> 245 -> 233, then a 9 ms step is dropped
    apply_register(ajic_pkg::REG_CONF_INTERVAL, 40'd280);
    apply_register(ajic_pkg::REG_NOMINAL_RATE, RATE_MAX);
    repeat (4) queue_job('0);
    drain_results();

    // targets of 280 and 279 above a kept 233: up steps under 10 ms dropped
    apply_register(ajic_pkg::REG_NOMINAL_RATE, 40'd10_760_000);
    queue_job(40'd5);
    drain_results();
    apply_register(ajic_pkg::REG_NOMINAL_RATE, 40'd10_800_000);
    queue_job(ajic_pkg::RATE_THRESH_KHS);
    drain_results();
    apply_register(ajic_pkg::REG_CONF_INTERVAL, 40'(ajic_pkg::MIN_INTERVAL_MS - 16'd1));
    queue_job(ajic_pkg::RATE_THRESH_KHS);
    drain_results();

    // --- random phases ---
    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();
      tx_rush = 1'b0;
      rx_rush = 1'b0;
      if (ph == 0) begin
        conf_v = 16'hFFFF;
        nom_v  = RATE_MAX;
      end else if (ph == 1) begin
        conf_v = 16'd0;
        nom_v  = 40'd1;
      end else begin
        conf_v = draw_conf();
        nom_v  = draw_nominal();
      end
      // both orders; sometimes just one register
      case ($urandom_range(0, 3))
        0: begin
          apply_register(ajic_pkg::REG_NOMINAL_RATE, nom_v);
          apply_register(ajic_pkg::REG_CONF_INTERVAL,
                         (draw_full40() & 40'hFF_FFFF_0000) | 40'(conf_v));
        end
        1: apply_register(ajic_pkg::REG_NOMINAL_RATE, nom_v);
        2: apply_register(ajic_pkg::REG_CONF_INTERVAL, 40'(conf_v));
        default: begin
          apply_register(ajic_pkg::REG_CONF_INTERVAL, 40'(conf_v));
          apply_register(ajic_pkg::REG_NOMINAL_RATE, nom_v);
        end
      endcase
      if (ph == 4) begin
        // output held off while the sender keeps pushing: input must back up
        tx_rush  = 1'b1;
        hold_req = 1'b1;
      end
      if (ph == 6) begin
        tx_rush = 1'b1;
        rx_rush = 1'b1;
      end
      for (n = 0; n < JOBS_PER_PH; n++) begin
        queue_job(draw_measured());
        // sender pause mid-phase until every result is back
        if (ph == 7 && n == JOBS_PER_PH / 2) drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("summary: %0d jobs / %0d results checked, %0d interval updates, %0d adaptive-off",
             jobs_taken, results_seen, updates_seen, off_jobs);
    $display("summary: %0d register writes, %0d-cycle output hold-off, %0d mismatches",
             reg_writes, HOLD_CYC, err_cnt);
    if (err_cnt == 0 && pending_intervals.size() == 0) begin
      $display("adaptive_job_interval_controller_unit regression: pass");
    end else begin
      $display("adaptive_job_interval_controller_unit regression: fail");
    end
    $finish;
  end

endmodule
